[src/dpls_pkg.sv]
// Shared widths, constants, register indexes and controller/datapath types.
package dpls_pkg;

    // Field widths
    localparam int unsigned SAMPLE_BITS  = 12;
    localparam int unsigned PEAK_BITS    = SAMPLE_BITS + 1;
    localparam int unsigned SPAN_BITS    = 8;
    localparam int unsigned NUM_BITS     = SAMPLE_BITS + SPAN_BITS;
    localparam int unsigned DIV_CNT_BITS = $clog2(SPAN_BITS);

    // Configuration port
    localparam int unsigned CFG_IDX_BITS  = 8;
    localparam int unsigned CFG_DATA_BITS = SAMPLE_BITS;
    localparam logic [CFG_IDX_BITS-1:0] REG_NOISE_FLOOR = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_LEVEL_SPAN  = CFG_IDX_BITS'(1);

    // Reset values
    localparam logic [SAMPLE_BITS-1:0] FLOOR_RESET = SAMPLE_BITS'(256);
    localparam logic [SPAN_BITS-1:0]   SPAN_RESET  = SPAN_BITS'(120);
    localparam logic [PEAK_BITS-1:0]   PEAK_RESET  = PEAK_BITS'(1) << SAMPLE_BITS;

    // Decay by 49/50: floor(peak * 49 * ceil(2^28 / 50) / 2^28).
    // Exact for peak * 49 below 2^28 / 44, which covers samples up to 16 bits.
    localparam int unsigned DECAY_SHIFT    = 28;
    localparam int unsigned DECAY_MUL_BITS = 28;
    localparam logic [DECAY_MUL_BITS-1:0] DECAY_MUL = DECAY_MUL_BITS'(263066790);
    localparam int unsigned DECAY_PROD_BITS = PEAK_BITS + DECAY_MUL_BITS;

    // Controller states
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DECAY = 5'b00010,
        S_PEAK  = 5'b00100,
        S_DIV   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic decay;
        logic peak;
        logic div_step;
        logic finish;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic div_last;
    } t_dp_sts;

endpackage

[src/decaying_peak_level_scaler.sv]
// Top level: decaying peak tracker with inverted level scaling.
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+--------------------------------
//  input   | i_valid     | o_ready     | i_sample
//  output  | o_valid     | i_ready     | o_level, o_peak_now
//  config  | i_cfg_valid | o_cfg_ready | i_cfg_index, i_cfg_data
//
// A request passes through accept, decay multiply, peak and scaling multiply,
// 8 restoring-divide steps (one quotient bit each) and finish; the next request is
// accepted only after the previous one has completed its finish step.
// A waiting result does not block the next request; only its finish step waits for
// the output register to free up. Synchronous reset sets noise floor 256, span 120,
// peak 4096. Config writes are always taken; indexes beyond the register list are dropped.
module decaying_peak_level_scaler (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [dpls_pkg::SAMPLE_BITS-1:0]    i_sample,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [dpls_pkg::SPAN_BITS-1:0]      o_level,
    output logic [dpls_pkg::PEAK_BITS-1:0]      o_peak_now,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dpls_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [dpls_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    dpls_pkg::t_dp_cmd w_cmd;
    dpls_pkg::t_dp_sts w_sts;

    assign o_cfg_ready = 1'b1;

    // Sequence requests
    dpls_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (w_cmd),
        .i_sts   (w_sts)
    );

    // Compute peak and level
    dpls_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_sample    (i_sample),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_level     (o_level),
        .o_peak_now  (o_peak_now)
    );

endmodule

[src/dpls_dp.sv]
// Datapath: config registers, peak decay, scaling multiply, restoring divider, result register.
module dpls_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  dpls_pkg::t_dp_cmd                    i_cmd,
    output dpls_pkg::t_dp_sts                    o_sts,
    input  logic [dpls_pkg::SAMPLE_BITS-1:0]     i_sample,
    input  logic                                 i_cfg_we,
    input  logic [dpls_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [dpls_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    output logic [dpls_pkg::SPAN_BITS-1:0]       o_level,
    output logic [dpls_pkg::PEAK_BITS-1:0]       o_peak_now
);

    logic [dpls_pkg::SAMPLE_BITS-1:0]     r_floor;
    logic [dpls_pkg::SPAN_BITS-1:0]       r_span;
    logic [dpls_pkg::PEAK_BITS-1:0]       r_peak;
    logic [dpls_pkg::SAMPLE_BITS-1:0]     r_sample;
    logic [dpls_pkg::PEAK_BITS-1:0]       r_decayed;
    logic [dpls_pkg::NUM_BITS-1:0]        r_rem;
    logic [dpls_pkg::NUM_BITS-1:0]        r_dsh;
    logic [dpls_pkg::SPAN_BITS-1:0]       r_quo;
    logic [dpls_pkg::DIV_CNT_BITS-1:0]    r_bit;
    logic [dpls_pkg::SPAN_BITS-1:0]       r_level;
    logic [dpls_pkg::PEAK_BITS-1:0]       r_peak_out;

    logic [dpls_pkg::DECAY_PROD_BITS-1:0] w_decay_prod;
    logic [dpls_pkg::PEAK_BITS-1:0]       w_floor_p1;
    logic [dpls_pkg::PEAK_BITS-1:0]       w_max_a;
    logic [dpls_pkg::PEAK_BITS-1:0]       w_peak_new;
    logic [dpls_pkg::PEAK_BITS-1:0]       w_den;
    logic [dpls_pkg::SAMPLE_BITS-1:0]     w_diff;
    logic [dpls_pkg::NUM_BITS-1:0]        w_num;
    logic                                 w_fits;

    // Decay product of the stored peak
    assign w_decay_prod = dpls_pkg::DECAY_PROD_BITS'(r_peak)
                        * dpls_pkg::DECAY_PROD_BITS'(dpls_pkg::DECAY_MUL);

    // New peak is the largest of decayed peak, sample and floor + 1
    assign w_floor_p1 = dpls_pkg::PEAK_BITS'(r_floor) + dpls_pkg::PEAK_BITS'(1);
    assign w_max_a    = (r_decayed > dpls_pkg::PEAK_BITS'(r_sample))
                      ? r_decayed : dpls_pkg::PEAK_BITS'(r_sample);
    assign w_peak_new = (w_max_a > w_floor_p1) ? w_max_a : w_floor_p1;
    assign w_den      = w_peak_new - dpls_pkg::PEAK_BITS'(r_floor);

    // Scaled distance above the floor; a quiet sample gives zero
    assign w_diff = r_sample - r_floor;
    assign w_num  = (r_sample > r_floor)
                  ? dpls_pkg::NUM_BITS'(w_diff) * dpls_pkg::NUM_BITS'(r_span)
                  : '0;

    // One restoring-division step
    assign w_fits = (r_rem >= r_dsh);

    assign o_sts.div_last = (r_bit == '0);

    // Configuration registers and tracked peak
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor <= dpls_pkg::FLOOR_RESET;
            r_span  <= dpls_pkg::SPAN_RESET;
            r_peak  <= dpls_pkg::PEAK_RESET;
        end else begin
            if (i_cfg_we && (i_cfg_index == dpls_pkg::REG_NOISE_FLOOR)) begin
                r_floor <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_index == dpls_pkg::REG_LEVEL_SPAN)) begin
                r_span <= i_cfg_data[dpls_pkg::SPAN_BITS-1:0];
            end
            if (i_cmd.peak) begin
                r_peak <= w_peak_new;
            end
        end
    end

    // Working registers of one request
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_sample;
        end
        if (i_cmd.decay) begin
            r_decayed <= w_decay_prod[dpls_pkg::DECAY_SHIFT +: dpls_pkg::PEAK_BITS];
        end
        if (i_cmd.peak) begin
            r_rem <= w_num;
            r_dsh <= {w_den, (dpls_pkg::SPAN_BITS-1)'(0)};
            r_quo <= '0;
            r_bit <= dpls_pkg::DIV_CNT_BITS'(dpls_pkg::SPAN_BITS - 1);
        end else if (i_cmd.div_step) begin
            if (w_fits) begin
                r_rem <= r_rem - r_dsh;
            end
            r_quo <= {r_quo[dpls_pkg::SPAN_BITS-2:0], w_fits};
            r_dsh <= r_dsh >> 1;
            r_bit <= r_bit - dpls_pkg::DIV_CNT_BITS'(1);
        end
        if (i_cmd.finish) begin
            r_level    <= r_span - r_quo;
            r_peak_out <= r_peak;
        end
    end

    assign o_level    = r_level;
    assign o_peak_now = r_peak_out;

    // The peak always ends above the floor, so the divisor is never zero
    a_peak_above_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.peak |=> (r_peak > dpls_pkg::PEAK_BITS'($past(r_floor))))
        else $error("peak not above noise floor");

    // Dividend below divisor * 2^SPAN_BITS: the quotient fits the level width
    a_quo_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.peak |=> ({1'b0, r_rem} < {r_dsh, 1'b0}))
        else $error("quotient overflows level width");

endmodule

[src/dpls_ctrl.sv]
// Controller: sequences one request through decay, peak, divide, and owns the output valid.
module dpls_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output dpls_pkg::t_dp_cmd o_cmd,
    input  dpls_pkg::t_dp_sts i_sts
);

    dpls_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             w_slot_free;

    assign w_slot_free = !r_out_valid || i_ready;
    assign o_ready     = (r_state == dpls_pkg::S_IDLE);
    assign o_valid     = r_out_valid;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            dpls_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = dpls_pkg::S_DECAY;
                end
            end
            dpls_pkg::S_DECAY: begin
                o_cmd.decay = 1'b1;
                n_state     = dpls_pkg::S_PEAK;
            end
            dpls_pkg::S_PEAK: begin
                o_cmd.peak = 1'b1;
                n_state    = dpls_pkg::S_DIV;
            end
            dpls_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = dpls_pkg::S_DONE;
                end
            end
            dpls_pkg::S_DONE: begin
                if (w_slot_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = dpls_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dpls_pkg::S_IDLE;
            end
        endcase
    end

    // Hold the result until taken, set it on finish
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dpls_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Work starts only after an accepted request
    a_decay_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dpls_pkg::S_DECAY) |-> $past(i_valid && o_ready))
        else $error("decay without accepted request");

    // A finished result shows up on the output next cycle
    a_finish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> o_valid)
        else $error("finished result not presented");

    // Finish never overwrites a result that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !o_cmd.finish)
        else $error("pending result overwritten");

endmodule
